// ===== sv/hmmd_pkg.sv =====
package hmmd_pkg;

  localparam int unsigned PosFracBitsDefault  = 16;
  localparam int unsigned QuatFracBitsDefault = 30;
  localparam int unsigned CarryFrac           = 31;

  // Configuration register indexes
  localparam logic [2:0] RegGain     = 3'd0;
  localparam logic [2:0] RegDeadzone = 3'd1;
  localparam logic [2:0] RegCap      = 3'd2;
  localparam logic [2:0] RegHInv     = 3'd3;
  localparam logic [2:0] RegVInv     = 3'd4;

  localparam logic [31:0] GainReset = 32'd65536000;
  localparam logic [14:0] CapReset  = 15'd64;

endpackage

// ===== sv/hand_motion_to_mouse_delta_core.sv =====
// Hand motion to pointer delta converter.
// Input channel (in_valid/in_ready) carries one tracking frame: previous and
// current hand position (Q16.16) and the head quaternion (Q2.30). The result
// channel (out_valid/out_ready) returns the hand displacement projected on
// the head right and up axes plus the pixel deltas for that frame.
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data); write
// it only while the block is idle.
// A single signed 33x33 multiplier is stepped through the nine quaternion
// products, the six projection terms, the magnitude squares and the two
// gain products, one product per cycle, followed by the pixel update of
// each axis, which is skipped when the frame is gated by the deadzone, a
// zero gain or a zero cap.
// The block takes one frame at a time; in_ready is high again once the
// result has been loaded into the output register, and a new frame may
// start while the previous result still waits for out_ready. If the
// receiver stalls longer than a frame's compute time, the second result
// waits in the datapath until the output register frees up.
// Synchronous active-low reset returns the registers to their defaults and
// clears the carried subpixel fractions.
module hand_motion_to_mouse_delta_core #(
  parameter int unsigned POS_FRAC_BITS  = hmmd_pkg::PosFracBitsDefault,
  parameter int unsigned QUAT_FRAC_BITS = hmmd_pkg::QuatFracBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_prev_x,
  input  logic signed [31:0] in_prev_y,
  input  logic signed [31:0] in_prev_z,
  input  logic signed [31:0] in_cur_x,
  input  logic signed [31:0] in_cur_y,
  input  logic signed [31:0] in_cur_z,
  input  logic signed [31:0] in_head_qx,
  input  logic signed [31:0] in_head_qy,
  input  logic signed [31:0] in_head_qz,
  input  logic signed [31:0] in_head_qw,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_right_meters,
  output logic signed [31:0] out_up_meters,
  output logic signed [15:0] out_delta_x,
  output logic signed [15:0] out_delta_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import hmmd_pkg::*;

  localparam int unsigned PShift = 2 * POS_FRAC_BITS;
  localparam logic signed [79:0] Lim = 80'sd1 <<< 47;
  localparam logic signed [35:0] One = 36'sd1 <<< QUAT_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_AXIS, S_PROJ, S_GATE, S_PIXX, S_PIXY, S_OUT
  } state_t;

  state_t state_r;
  logic [4:0] step_r;

  logic [31:0] gain_r;
  logic [16:0] dz_r;
  logic [14:0] cap_r;
  logic        hinv_r, vinv_r;
  logic signed [63:0] carry_x_r, carry_y_r;

  logic signed [32:0] d_r [3];
  logic signed [31:0] q_r [4];
  // quaternion products: xx yy zz xy xz yz xw yw zw
  logic signed [35:0] qp_r [9];
  logic signed [35:0] rax_r [3];
  logic signed [35:0] uax_r [3];
  logic signed [35:0] rs_r, us_r;
  logic signed [31:0] r_r, u_r;
  logic [63:0] mag_r;
  logic signed [79:0] px_r, py_r;
  logic signed [15:0] dx_r, dy_r;
  logic go_r;

  // Output register
  logic signed [31:0] o_r_r, o_u_r;
  logic signed [15:0] o_dx_r, o_dy_r;
  logic out_valid_r;

  // Shared multiplier
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  assign mp = ma * mb;

  function automatic logic signed [35:0] clamp_axis(input logic signed [35:0] v);
    if (v > One) return One;
    if (v < -One) return -One;
    return v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -36'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Shift gain product to 31 fraction bits and clamp to +-2^47
  function automatic logic signed [79:0] scale_p(input logic signed [79:0] p);
    logic signed [79:0] s;
    if (PShift >= CarryFrac) begin
      s = p >>> (PShift - CarryFrac);
      if (s > Lim) s = Lim;
      if (s < -Lim) s = -Lim;
    end else begin
      s = p;
      if (s > Lim) s = Lim;
      if (s < -Lim) s = -Lim;
      s = s <<< (CarryFrac - PShift);
      if (s > Lim) s = Lim;
      if (s < -Lim) s = -Lim;
    end
    return s;
  endfunction

  // Operand select per step
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (step_r)
      5'd0:  begin ma = 33'(q_r[0]); mb = 33'(q_r[0]); end
      5'd1:  begin ma = 33'(q_r[1]); mb = 33'(q_r[1]); end
      5'd2:  begin ma = 33'(q_r[2]); mb = 33'(q_r[2]); end
      5'd3:  begin ma = 33'(q_r[0]); mb = 33'(q_r[1]); end
      5'd4:  begin ma = 33'(q_r[0]); mb = 33'(q_r[2]); end
      5'd5:  begin ma = 33'(q_r[1]); mb = 33'(q_r[2]); end
      5'd6:  begin ma = 33'(q_r[0]); mb = 33'(q_r[3]); end
      5'd7:  begin ma = 33'(q_r[1]); mb = 33'(q_r[3]); end
      5'd8:  begin ma = 33'(q_r[2]); mb = 33'(q_r[3]); end
      5'd9:  begin ma = d_r[0]; mb = 33'(rax_r[0]); end
      5'd10: begin ma = d_r[1]; mb = 33'(rax_r[1]); end
      5'd11: begin ma = d_r[2]; mb = 33'(rax_r[2]); end
      5'd12: begin ma = d_r[0]; mb = 33'(uax_r[0]); end
      5'd13: begin ma = d_r[1]; mb = 33'(uax_r[1]); end
      5'd14: begin ma = d_r[2]; mb = 33'(uax_r[2]); end
      5'd15: begin ma = 33'(r_r); mb = 33'(r_r); end
      5'd16: begin ma = 33'(u_r); mb = 33'(u_r); end
      5'd17: begin ma = 33'(dz_r); mb = 33'(dz_r); end
      5'd18: begin ma = 33'(r_r); mb = $signed({1'b0, gain_r}); end
      5'd19: begin ma = 33'(u_r); mb = $signed({1'b0, gain_r}); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  // Pixel update for one axis
  logic signed [79:0] pa, acc, capv;
  logic signed [63:0] carry_in, carry_new;
  logic signed [79:0] dfull;
  logic ainv;
  always_comb begin
    pa       = (state_r == S_PIXX) ? px_r : py_r;
    carry_in = (state_r == S_PIXX) ? carry_x_r : carry_y_r;
    ainv     = (state_r == S_PIXX) ? hinv_r : vinv_r;
    if (ainv) pa = -pa;
    capv = 80'(cap_r) <<< CarryFrac;
    acc  = 80'(carry_in) + pa;
    if (acc > capv) acc = capv;
    if (acc < -capv) acc = -capv;
    if (acc >= 0) dfull = acc >>> CarryFrac;
    else dfull = -((-acc) >>> CarryFrac);
    carry_new = 64'(acc - (dfull <<< CarryFrac));
  end

  logic signed [65:0] qsh;
  assign qsh = mp >>> QUAT_FRAC_BITS;

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      gain_r      <= GainReset;
      dz_r        <= '0;
      cap_r       <= CapReset;
      hinv_r      <= 1'b0;
      vinv_r      <= 1'b0;
      carry_x_r   <= '0;
      carry_y_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          RegGain:     gain_r <= cfg_data;
          RegDeadzone: dz_r   <= cfg_data[16:0];
          RegCap:      cap_r  <= cfg_data[14:0];
          RegHInv:     hinv_r <= cfg_data[0];
          RegVInv:     vinv_r <= cfg_data[0];
          default: ;
        endcase
      end
      // Set on a load, drop once the transaction is taken
      if (state_r == S_OUT && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            d_r[0] <= 33'(in_cur_x) - 33'(in_prev_x);
            d_r[1] <= 33'(in_cur_y) - 33'(in_prev_y);
            d_r[2] <= 33'(in_cur_z) - 33'(in_prev_z);
            q_r[0] <= in_head_qx;
            q_r[1] <= in_head_qy;
            q_r[2] <= in_head_qz;
            q_r[3] <= in_head_qw;
            step_r <= '0;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // Advance through the quaternion products
          qp_r[step_r[3:0]] <= 36'(qsh);
          if (step_r == 5'd8) state_r <= S_AXIS;
          step_r <= step_r + 5'd1;
        end
        S_AXIS: begin
          rax_r[0] <= clamp_axis(One - 36'sd2 * (qp_r[1] + qp_r[2]));
          rax_r[1] <= clamp_axis(36'sd2 * (qp_r[3] + qp_r[8]));
          rax_r[2] <= clamp_axis(36'sd2 * (qp_r[4] - qp_r[7]));
          uax_r[0] <= clamp_axis(36'sd2 * (qp_r[3] - qp_r[8]));
          uax_r[1] <= clamp_axis(One - 36'sd2 * (qp_r[0] + qp_r[2]));
          uax_r[2] <= clamp_axis(36'sd2 * (qp_r[5] + qp_r[6]));
          rs_r <= '0;
          us_r <= '0;
          state_r <= S_PROJ;
        end
        S_PROJ: begin
          // Accumulate one projection term per cycle, right axis first
          if (step_r <= 5'd11) rs_r <= rs_r + 36'(qsh);
          else us_r <= us_r + 36'(qsh);
          if (step_r == 5'd14) begin
            r_r <= sat32(rs_r);
            u_r <= sat32(us_r + 36'(qsh));
            state_r <= S_GATE;
          end
          step_r <= step_r + 5'd1;
        end
        S_GATE: begin
          unique case (step_r)
            5'd15: mag_r <= 64'(mp);
            5'd16: mag_r <= mag_r + 64'(mp);
            5'd17: go_r <= (mag_r > 64'(mp)) && (gain_r != '0) && (cap_r != '0);
            5'd18: px_r <= scale_p(80'(mp));
            5'd19: py_r <= scale_p(80'(mp));
            default: ;
          endcase
          if (step_r == 5'd19) begin
            dx_r <= '0;
            dy_r <= '0;
            state_r <= go_r ? S_PIXX : S_OUT;
          end
          step_r <= step_r + 5'd1;
        end
        S_PIXX: begin
          dx_r <= 16'(dfull);
          carry_x_r <= carry_new;
          state_r <= S_PIXY;
        end
        S_PIXY: begin
          dy_r <= 16'(dfull);
          carry_y_r <= carry_new;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid_r || out_ready) begin
            o_r_r  <= r_r;
            o_u_r  <= u_r;
            o_dx_r <= dx_r;
            o_dy_r <= dy_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_right_meters = o_r_r;
  assign out_up_meters    = o_u_r;
  assign out_delta_x      = o_dx_r;
  assign out_delta_y      = o_dy_r;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a frame while busy");
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_delta_x) && $stable(out_right_meters))
    else $error("result overwritten while stalled");
  a_carry_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |=> $stable(carry_x_r) && $stable(carry_y_r))
    else $error("carry changed while idle");
`endif

endmodule

// ===== tb/sv/hmmd_checker.sv =====
`timescale 1ns / 100ps

module hmmd_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_prev_x,
  input  logic signed [31:0] in_prev_y,
  input  logic signed [31:0] in_prev_z,
  input  logic signed [31:0] in_cur_x,
  input  logic signed [31:0] in_cur_y,
  input  logic signed [31:0] in_cur_z,
  input  logic signed [31:0] in_head_qx,
  input  logic signed [31:0] in_head_qy,
  input  logic signed [31:0] in_head_qz,
  input  logic signed [31:0] in_head_qw,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_right_meters,
  input  logic signed [31:0] out_up_meters,
  input  logic signed [15:0] out_delta_x,
  input  logic signed [15:0] out_delta_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);
  import hmmd_pkg::*;

  typedef struct packed {
    logic signed [31:0] right_m;
    logic signed [31:0] up_m;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } delta_t;

  delta_t pending_deltas[$];

  logic [31:0] gain;
  logic [16:0] deadzone;
  logic [14:0] cap;
  logic        h_inv;
  logic        v_inv;
  longint      carry_x;
  longint      carry_y;

  localparam longint One = longint'(1) << QuatFracBitsDefault;
  localparam longint Lim = longint'(1) << 47;

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // arithmetic shift is a floor shift for signed operands
  function automatic longint qprod(longint a, longint b);
    return (a * b) >>> QuatFracBitsDefault;
  endfunction

  function automatic longint dot_axis(longint d0, longint d1, longint d2,
                                      longint a0, longint a1, longint a2);
    longint s;
    s = qprod(d0, a0) + qprod(d1, a1) + qprod(d2, a2);
    return clamp(s, -64'sh80000000, 64'sh7FFFFFFF);
  endfunction

  // update one axis carry and return the whole-pixel delta
  function automatic longint pixel_step(longint proj, logic inv, ref longint carry);
    longint p, capv, acc, d;
    p = proj * longint'({32'd0, gain});
    p = clamp(p >>> (2 * PosFracBitsDefault - CarryFrac), -Lim, Lim);
    if (inv) p = -p;
    capv = longint'(cap) << CarryFrac;
    acc = clamp(carry + p, -capv, capv);
    d = acc >= 0 ? (acc >>> CarryFrac) : -((-acc) >>> CarryFrac);
    carry = acc - (d << CarryFrac);
    return d;
  endfunction

  function automatic delta_t predict_deltas();
    longint qx, qy, qz, qw, xx, yy, zz, xy, xz, yz, xw, yw, zw;
    longint r0, r1, r2, u0, u1, u2, d0, d1, d2, r, u;
    longint unsigned mag2, dz2;
    delta_t res;
    qx = in_head_qx; qy = in_head_qy; qz = in_head_qz; qw = in_head_qw;
    xx = qprod(qx, qx); yy = qprod(qy, qy); zz = qprod(qz, qz);
    xy = qprod(qx, qy); xz = qprod(qx, qz); yz = qprod(qy, qz);
    xw = qprod(qx, qw); yw = qprod(qy, qw); zw = qprod(qz, qw);
    r0 = clamp(One - 2 * (yy + zz), -One, One);
    r1 = clamp(2 * (xy + zw), -One, One);
    r2 = clamp(2 * (xz - yw), -One, One);
    u0 = clamp(2 * (xy - zw), -One, One);
    u1 = clamp(One - 2 * (xx + zz), -One, One);
    u2 = clamp(2 * (yz + xw), -One, One);
    d0 = longint'(in_cur_x) - longint'(in_prev_x);
    d1 = longint'(in_cur_y) - longint'(in_prev_y);
    d2 = longint'(in_cur_z) - longint'(in_prev_z);
    r = dot_axis(d0, d1, d2, r0, r1, r2);
    u = dot_axis(d0, d1, d2, u0, u1, u2);
    mag2 = longint'(r * r) + longint'(u * u);
    dz2 = longint'(deadzone) * longint'(deadzone);
    res.right_m = r[31:0];
    res.up_m = u[31:0];
    res.dx = '0;
    res.dy = '0;
    if (mag2 > dz2 && gain != 0 && cap != 0) begin
      res.dx = 16'(pixel_step(r, h_inv, carry_x));
      res.dy = 16'(pixel_step(u, v_inv, carry_y));
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %0s at result %0d: got %0d want %0d", what, result_count, got, want);
    fail_count++;
  endtask

  // track registers, predict on input transactions, compare on output ones
  always @(posedge clk) begin
    delta_t got, want;
    if (!rst_n) begin
      gain <= GainReset;
      deadzone <= '0;
      cap <= CapReset;
      h_inv <= 1'b0;
      v_inv <= 1'b0;
      carry_x = 0;
      carry_y = 0;
      pending_deltas.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegGain:     gain <= cfg_data;
          RegDeadzone: deadzone <= cfg_data[16:0];
          RegCap:      cap <= cfg_data[14:0];
          RegHInv:     h_inv <= cfg_data[0];
          RegVInv:     v_inv <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) pending_deltas.push_back(predict_deltas());
      if (out_valid && out_ready) begin
        got = '{out_right_meters, out_up_meters, out_delta_x, out_delta_y};
        if (pending_deltas.size() == 0) begin
          $display("unexpected result %0d", result_count);
          fail_count++;
        end else begin
          want = pending_deltas.pop_front();
          if (got.right_m !== want.right_m) report_mismatch("right", got.right_m, want.right_m);
          if (got.up_m !== want.up_m) report_mismatch("up", got.up_m, want.up_m);
          if (got.dx !== want.dx) report_mismatch("delta_x", got.dx, want.dx);
          if (got.dy !== want.dy) report_mismatch("delta_y", got.dy, want.dy);
        end
        result_count++;
      end
    end
    pending_count = pending_deltas.size();
  end
endmodule

// ===== tb/sv/hand_motion_to_mouse_delta_core_test.sv =====
`timescale 1ns / 100ps

module hand_motion_to_mouse_delta_core_test;
  import hmmd_pkg::*;

  localparam int Phases = 6;
  localparam int ItemsPerPhase = 320;
  localparam int Q1 = 32'sh40000000;
  // index past the last register, must be ignored
  localparam logic [2:0] RegUnused = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] pos [6];
  logic signed [31:0] quat [4];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_right_meters, out_up_meters;
  logic signed [15:0] out_delta_x, out_delta_y;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending_count, result_count;
  bit quiet_tail = 1'b0;
  int frames_sent = 0;
  int stall_left = 0;

  initial begin
    foreach (pos[i]) pos[i] = '0;
    foreach (quat[i]) quat[i] = '0;
  end

  hand_motion_to_mouse_delta_core u_top (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_prev_x(pos[0]), .in_prev_y(pos[1]), .in_prev_z(pos[2]),
    .in_cur_x(pos[3]), .in_cur_y(pos[4]), .in_cur_z(pos[5]),
    .in_head_qx(quat[0]), .in_head_qy(quat[1]), .in_head_qz(quat[2]),
    .in_head_qw(quat[3]),
    .out_valid, .out_ready, .out_right_meters, .out_up_meters,
    .out_delta_x, .out_delta_y, .cfg_we, .cfg_index, .cfg_data
  );

  hmmd_checker u_check (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_prev_x(pos[0]), .in_prev_y(pos[1]), .in_prev_z(pos[2]),
    .in_cur_x(pos[3]), .in_cur_y(pos[4]), .in_cur_z(pos[5]),
    .in_head_qx(quat[0]), .in_head_qy(quat[1]), .in_head_qz(quat[2]),
    .in_head_qw(quat[3]),
    .out_valid, .out_ready, .out_right_meters, .out_up_meters,
    .out_delta_x, .out_delta_y, .cfg_we, .cfg_index, .cfg_data,
    .fail_count, .pending_count, .result_count
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // stall the receiver in random bursts, none in the quiet tail
  always @(posedge clk) begin
    if (quiet_tail) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left <= int'($urandom_range(0, 8));
    end else begin
      out_ready <= 1'b1;
    end
  end

  // drive one write; the caller drops cfg_we after the last one
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // hold one frame until accepted, with an optional idle burst first
  task automatic send_frame(logic signed [31:0] p [6], logic signed [31:0] q [4]);
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    foreach (pos[i]) pos[i] <= p[i];
    foreach (quat[i]) quat[i] <= q[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    frames_sent++;
  endtask

  function automatic logic signed [31:0] rand_quat_part(int mode);
    case (mode)
      0: return $urandom_range(0, 1) ? Q1 : -Q1;
      1: return 32'($signed($urandom_range(0, 32'h80000000)) - Q1);
      default: return 32'($signed($urandom_range(0, 32'h1000)) - 32'sh800);
    endcase
  endfunction

  // mostly small hand motions so the gated and carried paths are exercised
  task automatic send_random_frame();
    logic signed [31:0] p [6];
    logic signed [31:0] q [4];
    int sel;
    sel = $urandom_range(0, 9);
    foreach (p[i]) begin
      if (i < 3) p[i] = $urandom;
      else if (sel < 7) p[i] = p[i-3] + 32'($signed($urandom_range(0, 32'h8000)) - 32'sh4000);
      else p[i] = $urandom;
    end
    foreach (q[i]) q[i] = rand_quat_part($urandom_range(0, 2));
    send_frame(p, q);
  endtask

  // drop valid and wait until every accepted frame has come back
  task automatic drain_and_settle();
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (pending_count == 0);
    repeat (40) @(posedge clk);
  endtask

  task automatic directed_frames();
    logic signed [31:0] p [6];
    logic signed [31:0] q [4];
    int k;
    for (k = 0; k < 16; k++) begin
      foreach (p[i]) p[i] = '0;
      foreach (q[i]) q[i] = '0;
      q[k % 4] = (k & 4) ? -Q1 : Q1;
      case (k % 4)
        0: begin p[0] = 32'sh80000000; p[3] = 32'sh7FFFFFFF; end
        1: begin p[4] = 32'sh80000000; p[1] = 32'sh7FFFFFFF; p[5] = 32'sh7FFFFFFF; end
        2: begin p[3] = 32'sh00000100; p[4] = -32'sh00000080; end
        default: begin p[3] = 32'sh00010000; p[4] = 32'sh00008000; end
      endcase
      if (k >= 8) foreach (q[i]) q[i] = (k & 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      send_frame(p, q);
    end
  endtask

  initial begin
    int ph, n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_frames();
    for (ph = 0; ph < Phases; ph++) begin
      drain_and_settle();
      case (ph)
        0: begin
          write_reg(RegGain, 32'hFFFFFFFF); write_reg(RegCap, 32'h7FFF);
          write_reg(RegHInv, 32'd1); write_reg(RegVInv, 32'd0);
        end
        1: begin
          write_reg(RegGain, 32'd0); write_reg(RegDeadzone, 32'h1FFFF);
        end
        2: begin
          write_reg(RegGain, 32'h00010000); write_reg(RegDeadzone, 32'h00000400);
          write_reg(RegCap, 32'd0); write_reg(RegUnused, 32'hFFFFFFFF);
        end
        3: begin
          write_reg(RegGain, $urandom); write_reg(RegDeadzone, $urandom_range(0, 32'h200));
          write_reg(RegCap, $urandom_range(1, 200)); write_reg(RegVInv, 32'd1);
          write_reg(RegHInv, 32'd0);
        end
        4: begin
          write_reg(RegGain, 32'h00000001); write_reg(RegDeadzone, 32'h10000);
          write_reg(RegCap, 32'd1);
        end
        default: begin
          write_reg(RegGain, 32'd65536000); write_reg(RegDeadzone, 32'd0);
          write_reg(RegCap, 32'd64); write_reg(RegHInv, 32'd1);
          quiet_tail = 1'b1;
        end
      endcase
      cfg_we <= 1'b0;
      for (n = 0; n < ItemsPerPhase; n++) send_random_frame();
    end
    in_valid <= 1'b0;
    repeat (2) @(posedge clk);
    wait (pending_count == 0);
    repeat (60) @(posedge clk);
    $display("covered %0d frames and %0d results over %0d register settings",
             frames_sent, result_count, Phases + 1);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #5000000;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== sim.f =====
sv/hmmd_pkg.sv
sv/hand_motion_to_mouse_delta_core.sv
tb/sv/hmmd_checker.sv
tb/sv/hand_motion_to_mouse_delta_core_test.sv
